FILE: hw/rtl/magma_block_cipher_ecb_top_assert.svh
// Assertion macros for the Magma cipher pipeline.
// Used by magma_round through `include; empty when SYNTH is defined.
`ifndef MAGMA_BLOCK_CIPHER_ECB_TOP_ASSERT_SVH
`define MAGMA_BLOCK_CIPHER_ECB_TOP_ASSERT_SVH
`ifndef SYNTH
`define MAGMA_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("magma assertion failed");
`define MAGMA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("magma assertion failed");
`else
`define MAGMA_ASSERT(lbl, clk, rst, prop)
`define MAGMA_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: hw/rtl/magma_pkg.sv
// Shared types, constants and functions of the Magma cipher pipeline.
// No dependencies.
package magma_pkg;

  localparam int Rounds        = 32;
  localparam int KeyWords      = 8;
  localparam int KeyIdxWidth   = 3;
  localparam int CfgIndexWidth = 4;
  localparam int WordWidth     = 32;
  localparam int BlockWidth    = 64;
  localparam int RotLeft       = 11;
  localparam logic DirEncrypt  = 1'b0;
  localparam logic DirDecrypt  = 1'b1;

  typedef logic [KeyWords-1:0][WordWidth-1:0] key_set_t;

  // Word moving between two round stages.
  typedef struct packed {
    logic                 func;
    logic [WordWidth-1:0] hi;
    logic [WordWidth-1:0] lo;
  } stage_data_t;

  localparam logic [3:0] SBOX [0:7][0:15] = '{
    '{4'd12, 4'd4,  4'd6,  4'd2,  4'd10, 4'd5,  4'd11, 4'd9,
      4'd14, 4'd8,  4'd13, 4'd7,  4'd0,  4'd3,  4'd15, 4'd1},
    '{4'd6,  4'd8,  4'd2,  4'd3,  4'd9,  4'd10, 4'd5,  4'd12,
      4'd1,  4'd14, 4'd4,  4'd7,  4'd11, 4'd13, 4'd0,  4'd15},
    '{4'd11, 4'd3,  4'd5,  4'd8,  4'd2,  4'd15, 4'd10, 4'd13,
      4'd14, 4'd1,  4'd7,  4'd4,  4'd12, 4'd9,  4'd6,  4'd0},
    '{4'd12, 4'd8,  4'd2,  4'd1,  4'd13, 4'd4,  4'd15, 4'd6,
      4'd7,  4'd0,  4'd10, 4'd5,  4'd3,  4'd14, 4'd9,  4'd11},
    '{4'd7,  4'd15, 4'd5,  4'd10, 4'd8,  4'd1,  4'd6,  4'd13,
      4'd0,  4'd9,  4'd3,  4'd14, 4'd11, 4'd4,  4'd2,  4'd12},
    '{4'd5,  4'd13, 4'd15, 4'd6,  4'd9,  4'd2,  4'd12, 4'd10,
      4'd11, 4'd7,  4'd8,  4'd1,  4'd4,  4'd3,  4'd14, 4'd0},
    '{4'd8,  4'd14, 4'd2,  4'd5,  4'd6,  4'd9,  4'd1,  4'd12,
      4'd15, 4'd4,  4'd11, 4'd0,  4'd13, 4'd10, 4'd3,  4'd7},
    '{4'd1,  4'd7,  4'd14, 4'd13, 4'd0,  4'd5,  4'd8,  4'd3,
      4'd4,  4'd15, 4'd10, 4'd6,  4'd9,  4'd12, 4'd11, 4'd2}
  };

  // Key add, eight nibble substitutions, rotate left by 11.
  function automatic logic [WordWidth-1:0] round_fn(
      input logic [WordWidth-1:0] key, input logic [WordWidth-1:0] a);
    logic [WordWidth-1:0] s;
    logic [WordWidth-1:0] t;
    s = a + key;
    for (int j = 0; j < 8; j++) begin
      t[4*j +: 4] = SBOX[j][s[4*j +: 4]];
    end
    return {t[WordWidth-RotLeft-1:0], t[WordWidth-1:WordWidth-RotLeft]};
  endfunction

  // Key word used at pipeline round r; decrypt walks the schedule backwards.
  function automatic logic [KeyIdxWidth-1:0] key_idx(
      input int r, input logic dec, input int rounds);
    int i;
    int k;
    i = (dec == DirDecrypt) ? (rounds - 1 - r) : r;
    k = (i < rounds - KeyWords) ? i : (rounds - 1 - i);
    return k[KeyIdxWidth-1:0];
  endfunction

endpackage

FILE: hw/rtl/magma_if.sv
// Valid/ready channel interfaces for the Magma cipher block.
// Depends on magma_pkg for the field widths.
interface magma_in_if;
  logic                              valid;
  logic                              ready;
  logic                              func;
  logic [magma_pkg::BlockWidth-1:0]  block_in;
  modport source(output valid, func, block_in, input ready);
  modport sink(input valid, func, block_in, output ready);
endinterface

interface magma_out_if;
  logic                              valid;
  logic                              ready;
  logic [magma_pkg::BlockWidth-1:0]  block_out;
  modport source(output valid, block_out, input ready);
  modport sink(input valid, block_out, output ready);
endinterface

FILE: hw/rtl/magma_keys.sv
// Round key register file written through the configuration port.
// Depends on magma_pkg.
module magma_keys (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [magma_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  logic [magma_pkg::WordWidth-1:0]      cfg_data,
  output magma_pkg::key_set_t                  keys
);

  magma_pkg::key_set_t key_regs;

  // Drop writes beyond the eighth register.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_regs <= '0;
    end else if (cfg_wr_en &&
                 cfg_index < magma_pkg::CfgIndexWidth'(magma_pkg::KeyWords)) begin
      key_regs[cfg_index[magma_pkg::KeyIdxWidth-1:0]] <= cfg_data;
    end
  end

  assign keys = key_regs;

endmodule

FILE: hw/rtl/magma_round.sv
// One registered Feistel round of the Magma pipeline with its handshake.
// Depends on magma_pkg and the assertion macro header.
`include "magma_block_cipher_ecb_top_assert.svh"
module magma_round #(
  parameter int IDX    = 0,
  parameter int ROUNDS = magma_pkg::Rounds
) (
  input  logic                    clk,
  input  logic                    rst,
  input  magma_pkg::key_set_t     keys,
  input  logic                    valid_in,
  output logic                    ready_up,
  input  magma_pkg::stage_data_t  data_in,
  output logic                    valid,
  input  logic                    ready_dn,
  output magma_pkg::stage_data_t  data
);

  localparam logic [magma_pkg::KeyIdxWidth-1:0] EncIdx =
    magma_pkg::key_idx(IDX, magma_pkg::DirEncrypt, ROUNDS);
  localparam logic [magma_pkg::KeyIdxWidth-1:0] DecIdx =
    magma_pkg::key_idx(IDX, magma_pkg::DirDecrypt, ROUNDS);
  localparam bit LastRound = (IDX == ROUNDS - 1);

  logic [magma_pkg::WordWidth-1:0] key;
  logic [magma_pkg::WordWidth-1:0] g;
  magma_pkg::stage_data_t          data_next;

  assign key = (data_in.func == magma_pkg::DirDecrypt) ? keys[DecIdx] : keys[EncIdx];
  assign g   = data_in.hi ^ magma_pkg::round_fn(key, data_in.lo);

  // The last round leaves the halves in place.
  always_comb begin
    data_next.func = data_in.func;
    if (LastRound) begin
      data_next.hi = g;
      data_next.lo = data_in.lo;
    end else begin
      data_next.hi = data_in.lo;
      data_next.lo = g;
    end
  end

  // Take a word when empty or when the current one moves on.
  assign ready_up = !valid || ready_dn;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_up) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && valid_in) begin
      data <= data_next;
    end
  end

  `MAGMA_ASSERT_NEXT(a_stall_hold, clk, rst, valid && !ready_dn, valid && $stable(data))
  `MAGMA_ASSERT_NEXT(a_load, clk, rst, valid_in && ready_up, valid)
  `MAGMA_ASSERT_NEXT(a_drain, clk, rst, !valid_in && ready_up, !valid)

endmodule

FILE: hw/rtl/magma_block_cipher_ecb_top.sv
// Magma 64-bit block cipher, ECB, as a fully unrolled round pipeline.
// Depends on magma_pkg, magma_if, magma_keys and magma_round.
//
// One block enters per clock cycle unless the output applies backpressure;
// the ROUNDS Feistel rounds (32 at the default) are each one register stage.
// Each stage holds its word when the next one is full and stalled, so
// backpressure fills bubbles before the input stops. The eight key words are
// written at cfg_index 0..7 (higher indexes are ignored) and must only change
// while the pipeline is empty; func selects encrypt (0) or decrypt (1) per
// block.
module magma_block_cipher_ecb_top #(
  parameter int ROUNDS = magma_pkg::Rounds
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [magma_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  logic [magma_pkg::WordWidth-1:0]      cfg_data,
  magma_in_if.sink                             in_ch,
  magma_out_if.source                          out_ch
);

  localparam int Ww = magma_pkg::WordWidth;

  magma_pkg::key_set_t    keys;
  logic                   valid_s [0:ROUNDS];
  logic                   ready_s [0:ROUNDS];
  magma_pkg::stage_data_t data_s  [0:ROUNDS];

  magma_keys u_keys (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .keys      (keys)
  );

  assign valid_s[0]     = in_ch.valid;
  assign in_ch.ready    = ready_s[0];
  assign data_s[0].func = in_ch.func;
  assign data_s[0].hi   = in_ch.block_in[2*Ww-1:Ww];
  assign data_s[0].lo   = in_ch.block_in[Ww-1:0];

  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    magma_round #(
      .IDX    (r),
      .ROUNDS (ROUNDS)
    ) u_round (
      .clk      (clk),
      .rst      (rst),
      .keys     (keys),
      .valid_in (valid_s[r]),
      .ready_up (ready_s[r]),
      .data_in  (data_s[r]),
      .valid    (valid_s[r+1]),
      .ready_dn (ready_s[r+1]),
      .data     (data_s[r+1])
    );
  end

  assign ready_s[ROUNDS]  = out_ch.ready;
  assign out_ch.valid     = valid_s[ROUNDS];
  assign out_ch.block_out = {data_s[ROUNDS].hi, data_s[ROUNDS].lo};

endmodule
